// ----- hdl/bbc_pkg.sv -----
`default_nettype none
// Package: types, constants and status codes of the bracket balance checker
package bbc_pkg;

  localparam int STACK_DEPTH  = 1024;
  localparam int SYMBOL_SLOTS = 64;
  localparam int CFG_WORDS    = 8;
  localparam int CFG_WIDTH    = 64;
  localparam int CFG_IDX_W    = 4;

  localparam int ADDR_W  = $clog2(STACK_DEPTH);
  localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);

  localparam int ROW_W = 24;
  localparam int COL_W = 16;
  localparam int SYM_W = 8;

  localparam logic [ROW_W-1:0] ROW_MAX = '1;
  localparam logic [COL_W-1:0] COL_MAX = '1;
  localparam logic [SYM_W-1:0] NEWLINE_BYTE = 8'h0A;

  localparam logic [CFG_WIDTH-1:0] SYMBOL_WORD0_RESET = 64'h0000_2928_7D7B_5D5B;

  localparam logic [DEPTH_W-1:0] DEPTH_FULL = DEPTH_W'(STACK_DEPTH);
  localparam logic [SYMBOL_SLOTS-1:0] SLOT_ONE = SYMBOL_SLOTS'(1);

  typedef enum logic {
    CMD_BYTE = 1'b0,
    CMD_END  = 1'b1
  } command_t;

  typedef enum logic [2:0] {
    ST_ACCEPTED        = 3'd0,
    ST_UNMATCHED_CLOSE = 3'd1,
    ST_UNMATCHED_OPEN  = 3'd2,
    ST_OVERFLOW        = 3'd3,
    ST_BALANCED        = 3'd4,
    ST_HALTED          = 3'd5
  } status_t;

  typedef struct packed {
    command_t         command;
    logic [SYM_W-1:0] text_byte;
  } in_item_t;

  typedef struct packed {
    status_t          status;
    logic [ROW_W-1:0] report_row;
    logic [COL_W-1:0] report_column;
    logic [SYM_W-1:0] report_symbol;
  } out_item_t;

  // One stack entry: column, row, symbol (symbol in the low byte)
  typedef struct packed {
    logic [COL_W-1:0] column;
    logic [ROW_W-1:0] row;
    logic [SYM_W-1:0] symbol;
  } frame_t;

  localparam int FRAME_W = $bits(frame_t);

endpackage
`default_nettype wire

// ----- hdl/bbc_ram.sv -----
`default_nettype none
// Generic simple dual-port RAM with one write port and a registered read port
module bbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

// ----- hdl/bracket_balance_checker_unit.sv -----
`default_nettype none
// Top level: bracket balance checker, stack held in a synchronous RAM
//
//   channel  | direction | handshake             | payload
//   ---------+-----------+-----------------------+---------------------------
//   in_      | input     | in_valid / in_stall   | bbc_pkg::in_item_t
//   out_     | output    | out_valid / out_stall | bbc_pkg::out_item_t
//   cfg_     | input     | cfg_wr_en             | cfg_index, cfg_data
//
// One request per cycle while in_stall is low; every request yields exactly one result, registered.
// The top of the stack lives in a register and the entry under it is read from the RAM in
// the cycle before it is needed, which sustains that rate.
// Reset (rst_n low, synchronous) empties the stack, sets row 1 / column 0,
// clears the halt and reloads the default symbol list; no RAM clearing pass.
// A two-deep output (register + skid) keeps accepting while a result waits;
// in_stall rises only when both are full.
module bracket_balance_checker_unit (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // request channel
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire bbc_pkg::in_item_t               in_data,
  // result channel
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output bbc_pkg::out_item_t                   out_data,
  // configuration
  input  wire logic                            cfg_wr_en,
  input  wire logic [bbc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [bbc_pkg::CFG_WIDTH-1:0]   cfg_data
);

  // ---------------------------------------------------------------------
  // Symbol list registers
  // ---------------------------------------------------------------------
  logic [bbc_pkg::CFG_WIDTH-1:0] cfg_word_r [bbc_pkg::CFG_WORDS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int w = 0; w < bbc_pkg::CFG_WORDS; w++) begin
        cfg_word_r[w] <= '0;
      end
      cfg_word_r[0] <= bbc_pkg::SYMBOL_WORD0_RESET;
    end else if (cfg_wr_en && (cfg_index < bbc_pkg::CFG_IDX_W'(bbc_pkg::CFG_WORDS))) begin
      cfg_word_r[cfg_index[$clog2(bbc_pkg::CFG_WORDS)-1:0]] <= cfg_data;
    end
  end

  // ---------------------------------------------------------------------
  // Scan state
  // ---------------------------------------------------------------------
  logic [bbc_pkg::DEPTH_W-1:0] depth_r,   depth_nxt;
  logic [bbc_pkg::ROW_W-1:0]   row_r,     row_nxt;
  logic [bbc_pkg::COL_W-1:0]   col_r,     col_nxt;
  logic                        halted_r,  halted_nxt;
  bbc_pkg::frame_t             top_r,     top_nxt;     // top of stack, valid when depth_r > 0
  logic                        fwd_r,     fwd_nxt;     // entry below top was just written
  bbc_pkg::frame_t             fwd_data_r;

  // output register + skid
  logic                        out_valid_r, out_valid_nxt;
  bbc_pkg::out_item_t          out_data_r,  out_data_nxt;
  logic                        skid_valid_r, skid_valid_nxt;
  bbc_pkg::out_item_t          skid_data_r,  skid_data_nxt;

  logic in_fire;
  assign in_stall = skid_valid_r;
  assign in_fire  = in_valid && !skid_valid_r;

  // ---------------------------------------------------------------------
  // Stack RAM: holds entries 0 .. depth-2, the top sits in top_r
  // ---------------------------------------------------------------------
  logic                         mem_wr_en;
  logic [bbc_pkg::ADDR_W-1:0]   mem_wr_addr;
  logic [bbc_pkg::ADDR_W-1:0]   mem_rd_addr;
  logic [bbc_pkg::FRAME_W-1:0]  mem_rd_data;
  logic [bbc_pkg::DEPTH_W-1:0]  depth_m1;
  logic [bbc_pkg::DEPTH_W-1:0]  rd_full;
  bbc_pkg::frame_t              under;

  assign depth_m1    = depth_r - bbc_pkg::DEPTH_W'(1);
  assign mem_wr_addr = depth_m1[bbc_pkg::ADDR_W-1:0];
  // Read the entry that will sit under the top after this cycle
  assign rd_full     = depth_nxt - bbc_pkg::DEPTH_W'(2);
  assign mem_rd_addr = rd_full[bbc_pkg::ADDR_W-1:0];
  assign under       = fwd_r ? fwd_data_r : bbc_pkg::frame_t'(mem_rd_data);

  bbc_ram #(
    .WIDTH (bbc_pkg::FRAME_W),
    .DEPTH (bbc_pkg::STACK_DEPTH)
  ) u_stack_ram (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (top_r),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  // ---------------------------------------------------------------------
  // Symbol lookup: parallel compare, first match via lowest set bit
  // ---------------------------------------------------------------------
  logic [bbc_pkg::CFG_WORDS*bbc_pkg::CFG_WIDTH-1:0] sym_flat;
  logic [bbc_pkg::SYMBOL_SLOTS-1:0] zero_mask, eq_mask, odd_mask, pair_mask;
  logic [bbc_pkg::SYMBOL_SLOTS-1:0] valid_mask, hit_mask, first_oh;
  logic is_open, is_close, pair_ok;

  always_comb begin
    for (int w = 0; w < bbc_pkg::CFG_WORDS; w++) begin
      sym_flat[w*bbc_pkg::CFG_WIDTH +: bbc_pkg::CFG_WIDTH] = cfg_word_r[w];
    end
  end

  always_comb begin
    for (int i = 0; i < bbc_pkg::SYMBOL_SLOTS; i++) begin
      zero_mask[i] = (sym_flat[i*8 +: 8] == '0);
      eq_mask[i]   = (sym_flat[i*8 +: 8] == in_data.text_byte);
      odd_mask[i]  = (i % 2 == 1);
      if (i % 2 == 1) begin
        pair_mask[i] = (sym_flat[(i-1)*8 +: 8] == top_r.symbol);
      end else begin
        pair_mask[i] = 1'b0;
      end
    end
    // slots below the first zero byte; all slots when there is none
    valid_mask = (zero_mask & (~zero_mask + bbc_pkg::SLOT_ONE)) - bbc_pkg::SLOT_ONE;
    hit_mask   = eq_mask & valid_mask;
    first_oh   = hit_mask & (~hit_mask + bbc_pkg::SLOT_ONE);
    is_open    = |(first_oh & ~odd_mask);
    is_close   = |(first_oh & odd_mask);
    pair_ok    = |(first_oh & pair_mask);
  end

  // ---------------------------------------------------------------------
  // Step logic
  // ---------------------------------------------------------------------
  logic [bbc_pkg::ROW_W-1:0] row_inc;
  logic [bbc_pkg::COL_W-1:0] col_inc;
  logic                      push_ok;
  bbc_pkg::out_item_t        res;

  assign row_inc = (row_r != bbc_pkg::ROW_MAX) ? row_r + 1'b1 : row_r;
  assign col_inc = (col_r != bbc_pkg::COL_MAX) ? col_r + 1'b1 : col_r;

  always_comb begin
    depth_nxt  = depth_r;
    row_nxt    = row_r;
    col_nxt    = col_r;
    halted_nxt = halted_r;
    top_nxt    = top_r;
    fwd_nxt    = 1'b0;
    mem_wr_en  = 1'b0;
    push_ok    = 1'b0;

    res.status        = bbc_pkg::ST_ACCEPTED;
    res.report_row    = row_r;
    res.report_column = col_r;
    res.report_symbol = '0;

    if (in_data.command == bbc_pkg::CMD_END) begin
      if (halted_r) begin
        res.status = bbc_pkg::ST_HALTED;
      end else if (depth_r != '0) begin
        res.status        = bbc_pkg::ST_UNMATCHED_OPEN;
        res.report_row    = top_r.row;
        res.report_column = top_r.column;
        res.report_symbol = top_r.symbol;
      end else begin
        res.status = bbc_pkg::ST_BALANCED;
      end
      if (in_fire) begin
        depth_nxt  = '0;
        row_nxt    = bbc_pkg::ROW_W'(1);
        col_nxt    = '0;
        halted_nxt = 1'b0;
      end
    end else if (halted_r) begin
      res.status = bbc_pkg::ST_HALTED;
    end else if (in_data.text_byte == bbc_pkg::NEWLINE_BYTE) begin
      res.report_row    = row_inc;
      res.report_column = '0;
      if (in_fire) begin
        row_nxt = row_inc;
        col_nxt = '0;
      end
    end else begin
      res.report_column = col_inc;
      if (in_fire) begin
        col_nxt = col_inc;
      end
      if (is_open) begin
        if (depth_r == bbc_pkg::DEPTH_FULL) begin
          res.status        = bbc_pkg::ST_OVERFLOW;
          res.report_symbol = in_data.text_byte;
          if (in_fire) begin
            halted_nxt = 1'b1;
          end
        end else if (in_fire) begin
          push_ok        = 1'b1;
          top_nxt.symbol = in_data.text_byte;
          top_nxt.row    = row_r;
          top_nxt.column = col_inc;
          depth_nxt      = depth_r + bbc_pkg::DEPTH_W'(1);
          // old top moves into the RAM; it becomes the entry under the new top
          mem_wr_en      = (depth_r != '0);
          fwd_nxt        = (depth_r != '0);
        end
      end else if (is_close) begin
        if ((depth_r == '0) || !pair_ok) begin
          res.status        = bbc_pkg::ST_UNMATCHED_CLOSE;
          res.report_symbol = in_data.text_byte;
          if (in_fire) begin
            halted_nxt = 1'b1;
          end
        end else if (in_fire) begin
          top_nxt   = under;
          depth_nxt = depth_m1;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Output register and skid
  // ---------------------------------------------------------------------
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (!out_valid_r || !out_stall) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = in_fire;
        if (in_fire) begin
          out_data_nxt = res;
        end
      end
    end else if (in_fire) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r      <= '0;
      row_r        <= bbc_pkg::ROW_W'(1);
      col_r        <= '0;
      halted_r     <= 1'b0;
      fwd_r        <= 1'b0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      depth_r      <= depth_nxt;
      row_r        <= row_nxt;
      col_r        <= col_nxt;
      halted_r     <= halted_nxt;
      fwd_r        <= fwd_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    top_r       <= top_nxt;
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
    if (mem_wr_en) begin
      fwd_data_r <= top_r;
    end
  end

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid holds a result while the output register is empty");

  a_push_depth: assert property (@(posedge clk) disable iff (!rst_n)
    push_ok |=> (depth_r == $past(depth_r) + bbc_pkg::DEPTH_W'(1)))
    else $error("push did not raise the stack depth");

  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (halted_r && in_fire && (in_data.command == bbc_pkg::CMD_BYTE))
      |=> (halted_r && $stable(depth_r)))
    else $error("text byte changed state while halted");

  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_data.command == bbc_pkg::CMD_END))
      |=> ((depth_r == '0) && !halted_r && (row_r == bbc_pkg::ROW_W'(1)) && (col_r == '0)))
    else $error("end of text did not restart the scan");

  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (depth_r == bbc_pkg::DEPTH_FULL) |=> (depth_r <= bbc_pkg::DEPTH_FULL))
    else $error("stack depth beyond capacity");

endmodule
`default_nettype wire

// ----- test/tb_bracket_balance_checker_unit.sv -----
`timescale 1ns / 1ps
// Testbench: bracket balance checker, directed table plus random documents vs. a scan predictor
module tb_bracket_balance_checker_unit;
  import bbc_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;  // cycles with no request and no result
  localparam int SETTLE_CYCLES  = 4;     // registered block plus two-deep output, with margin
  localparam int DIRECTED_ROWS  = 23;

  // Default symbol list characters
  localparam logic [SYM_W-1:0] SQ_OPEN  = 8'h5B;
  localparam logic [SYM_W-1:0] SQ_CLOSE = 8'h5D;
  localparam logic [SYM_W-1:0] CU_OPEN  = 8'h7B;
  localparam logic [SYM_W-1:0] CU_CLOSE = 8'h7D;
  localparam logic [SYM_W-1:0] RD_OPEN  = 8'h28;
  localparam logic [SYM_W-1:0] RD_CLOSE = 8'h29;
  localparam logic [SYM_W-1:0] PLAIN_X  = 8'h78;

  // One row of the directed table; typed rows carry their own expected report
  typedef struct packed {
    command_t         cmd;
    logic [SYM_W-1:0] text;
    bit               typed;
    status_t          st;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [SYM_W-1:0] sym;
  } directed_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_item_t             in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_data;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_WIDTH-1:0] cfg_data = '0;

  bracket_balance_checker_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Scan predictor: its own copy of the symbol list, stack and position
  // ---------------------------------------------------------------------------
  logic [CFG_WIDTH-1:0] list_words [CFG_WORDS];
  logic [CFG_WIDTH-1:0] staged_words [CFG_WORDS];
  frame_t               scan_stack [STACK_DEPTH];
  int                   scan_depth;
  logic [ROW_W-1:0]     scan_row;
  logic [COL_W-1:0]     scan_col;
  bit                   scan_halted;

  out_item_t expected_reports [$];

  // Run bookkeeping
  int send_idle_pct = 10;
  int recv_idle_pct = 55;
  int requests_sent = 0;
  int results_checked = 0;
  int mismatch_count = 0;
  int lists_loaded = 1;  // reset list counts as the first
  int quiet_cycles = 0;
  int status_tally [6] = '{default: 0};

  function automatic logic [SYM_W-1:0] list_byte(input int pos);
    return list_words[pos / 8][(pos % 8) * 8 +: 8];
  endfunction

  // First list position holding b, -1 if the list ends first
  function automatic int first_slot_of(input logic [SYM_W-1:0] b);
    int pos;
    for (pos = 0; pos < SYMBOL_SLOTS; pos++) begin
      if (list_byte(pos) == 8'h00) return -1;
      if (list_byte(pos) == b) return pos;
    end
    return -1;
  endfunction

  function automatic int active_list_len();
    int pos;
    for (pos = 0; pos < SYMBOL_SLOTS; pos++)
      if (list_byte(pos) == 8'h00) return pos;
    return SYMBOL_SLOTS;
  endfunction

  function automatic void restart_scan();
    scan_depth  = 0;
    scan_row    = ROW_W'(1);
    scan_col    = '0;
    scan_halted = 1'b0;
  endfunction

  // Advances the predictor by one request and returns the report it owes
  function automatic out_item_t scan_step(input in_item_t req);
    out_item_t        rep;
    frame_t           top;
    int               slot;
    logic [SYM_W-1:0] b;
    b = req.text_byte;
    if (req.command == CMD_END) begin
      if (scan_halted) begin
        rep = '{ST_HALTED, scan_row, scan_col, 8'h00};
      end else if (scan_depth > 0) begin
        top = scan_stack[scan_depth - 1];
        rep = '{ST_UNMATCHED_OPEN, top.row, top.column, top.symbol};
      end else begin
        rep = '{ST_BALANCED, scan_row, scan_col, 8'h00};
      end
      restart_scan();
      return rep;
    end
    if (scan_halted) return '{ST_HALTED, scan_row, scan_col, 8'h00};
    if (b == NEWLINE_BYTE) begin
      if (scan_row != ROW_MAX) scan_row++;
      scan_col = '0;
      return '{ST_ACCEPTED, scan_row, scan_col, 8'h00};
    end
    if (scan_col != COL_MAX) scan_col++;
    // NUL is plain text and never looked up
    slot = (b == 8'h00) ? -1 : first_slot_of(b);
    if (slot >= 0 && slot % 2 == 0) begin
      if (scan_depth >= STACK_DEPTH) begin
        scan_halted = 1'b1;
        return '{ST_OVERFLOW, scan_row, scan_col, b};
      end
      scan_stack[scan_depth] = '{column: scan_col, row: scan_row, symbol: b};
      scan_depth++;
    end else if (slot >= 0) begin
      // closer pairs with the list byte just before it; stack untouched on error
      if (scan_depth == 0 || scan_stack[scan_depth - 1].symbol != list_byte(slot - 1)) begin
        scan_halted = 1'b1;
        return '{ST_UNMATCHED_CLOSE, scan_row, scan_col, b};
      end
      scan_depth--;
    end
    return '{ST_ACCEPTED, scan_row, scan_col, 8'h00};
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus generation
  // ---------------------------------------------------------------------------

  // List slot of a closer that pops the current top, -1 if none
  function automatic int matching_closer_slot();
    int               pos;
    int               len;
    logic [SYM_W-1:0] top_sym;
    if (scan_depth == 0) return -1;
    len     = active_list_len();
    top_sym = scan_stack[scan_depth - 1].symbol;
    for (pos = 1; pos < len; pos += 2)
      if (list_byte(pos - 1) == top_sym && first_slot_of(list_byte(pos)) == pos) return pos;
    return -1;
  endfunction

  // Mostly well-formed text: closers become mandatory as the document runs out
  function automatic logic [SYM_W-1:0] pick_text_byte(input int remaining);
    int roll;
    int slot;
    int len;
    roll = $urandom_range(99);
    slot = matching_closer_slot();
    len  = active_list_len();
    if (slot >= 0 && (remaining <= scan_depth || roll < 30)) return list_byte(slot);
    if (len > 0 && roll < 55) return list_byte($urandom_range(len - 1));
    if (roll < 63) return NEWLINE_BYTE;
    if (roll < 68) return 8'h00;
    return 8'($urandom);
  endfunction

  // Drives one request, holds it until accepted, then records the owed report
  task automatic send_request(input in_item_t req, input bit typed, input out_item_t typed_want);
    out_item_t predicted;
    // sender idles on each cycle with the given chance
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = scan_step(req);
    expected_reports.push_back(typed ? typed_want : predicted);
    requests_sent++;
  endtask

  task automatic send_byte(input logic [SYM_W-1:0] b);
    send_request('{CMD_BYTE, b}, 1'b0, '0);
  endtask

  // text_byte is don't-care on end of text, so it carries noise
  task automatic send_end();
    send_request('{CMD_END, 8'($urandom)}, 1'b0, '0);
  endtask

  // Random documents, each closed by end of text; bytes sent while halted don't count
  task automatic random_documents(input int item_goal);
    int sent;
    int doc_len;
    int k;
    sent = 0;
    while (sent < item_goal) begin
      doc_len = $urandom_range(1, 40);
      for (k = 0; k < doc_len; k++) begin
        if (scan_halted && $urandom_range(3) != 0) break;
        if (!scan_halted) sent++;
        send_byte(pick_text_byte(doc_len - k));
      end
      send_end();
      sent++;
    end
  endtask

  // Wait until the block owes nothing, then let the pipeline empty
  task automatic quiesce();
    in_valid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all symbol words plus one write to an unused index, which must be ignored
  task automatic apply_list();
    int i;
    for (i = 0; i < CFG_WORDS; i++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_data  <= staged_words[i];
      @(posedge clk);
      list_words[i] = staged_words[i];
    end
    cfg_index <= CFG_IDX_W'($urandom_range(CFG_WORDS, (1 << CFG_IDX_W) - 1));
    cfg_data  <= {$urandom, $urandom};
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    lists_loaded++;
  endtask

  // Random list of slots_used symbols, zero terminated when short, garbage after.
  // Half the symbols come from a narrow band so duplicates and clashes show up.
  task automatic stage_random_list(input int slots_used);
    int               pos;
    logic [SYM_W-1:0] b;
    for (pos = 0; pos < SYMBOL_SLOTS; pos++) begin
      if (pos < slots_used)
        b = $urandom_range(1) ? 8'($urandom_range(8'h21, 8'h2F)) : 8'($urandom_range(1, 255));
      else if (pos == slots_used)
        b = 8'h00;
      else
        b = 8'($urandom);
      staged_words[pos / 8][(pos % 8) * 8 +: 8] = b;
    end
  endtask

  task automatic stage_uniform_list(input logic [CFG_WIDTH-1:0] word_value);
    int i;
    for (i = 0; i < CFG_WORDS; i++) staged_words[i] = word_value;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stall, in-order compare against owed reports
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_checked++;
      if (out_data.status <= ST_HALTED) status_tally[out_data.status]++;
      if (expected_reports.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("Unexpected result: status %0d row %0d col %0d sym %02h",
                   out_data.status, out_data.report_row, out_data.report_column,
                   out_data.report_symbol);
      end else begin
        want = expected_reports.pop_front();
        if (want.status !== out_data.status || want.report_row !== out_data.report_row ||
            want.report_column !== out_data.report_column ||
            want.report_symbol !== out_data.report_symbol) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("Mismatch on result %0d: expected status %0d row %0d col %0d sym %02h",
                     results_checked, want.status, want.report_row, want.report_column,
                     want.report_symbol);
            $display("  got status %0d row %0d col %0d sym %02h",
                     out_data.status, out_data.report_row, out_data.report_column,
                     out_data.report_symbol);
          end
        end
      end
    end
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Watchdog: any accepted request or result restarts the count
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Timeout: nothing accepted for %0d cycles, %0d reports still owed",
                 WATCHDOG_LIMIT, expected_reports.size());
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  directed_row_t directed_table [DIRECTED_ROWS];

  initial begin : main_sequence
    int i;
    // predictor starts from the reset state of the block
    list_words[0] = SYMBOL_WORD0_RESET;
    for (i = 1; i < CFG_WORDS; i++) list_words[i] = '0;
    restart_scan();

    directed_table = '{
      // end of text right after reset: balanced at row 1, column 0
      '{CMD_END,  8'h00,        1'b1, ST_BALANCED,        24'd1, 16'd0, 8'h00},
      // NUL and 0xFF are plain text, newline clears the column
      '{CMD_BYTE, 8'h00,        1'b1, ST_ACCEPTED,        24'd1, 16'd1, 8'h00},
      '{CMD_BYTE, 8'hFF,        1'b1, ST_ACCEPTED,        24'd1, 16'd2, 8'h00},
      '{CMD_BYTE, NEWLINE_BYTE, 1'b1, ST_ACCEPTED,        24'd2, 16'd0, 8'h00},
      // every pair of the default list, nested and closed
      '{CMD_BYTE, SQ_OPEN,      1'b0, ST_ACCEPTED,        24'd0, 16'd0, 8'h00},
      '{CMD_BYTE, CU_OPEN,      1'b0, ST_ACCEPTED,        24'd0, 16'd0, 8'h00},
      '{CMD_BYTE, RD_OPEN,      1'b0, ST_ACCEPTED,        24'd0, 16'd0, 8'h00},
      '{CMD_BYTE, RD_CLOSE,     1'b0, ST_ACCEPTED,        24'd0, 16'd0, 8'h00},
      '{CMD_BYTE, CU_CLOSE,     1'b0, ST_ACCEPTED,        24'd0, 16'd0, 8'h00},
      '{CMD_BYTE, SQ_CLOSE,     1'b0, ST_ACCEPTED,        24'd0, 16'd0, 8'h00},
      '{CMD_END,  8'h00,        1'b1, ST_BALANCED,        24'd2, 16'd6, 8'h00},
      // opener left open across a newline: reported at its own position
      '{CMD_BYTE, RD_OPEN,      1'b0, ST_ACCEPTED,        24'd0, 16'd0, 8'h00},
      '{CMD_BYTE, NEWLINE_BYTE, 1'b0, ST_ACCEPTED,        24'd0, 16'd0, 8'h00},
      '{CMD_BYTE, PLAIN_X,      1'b0, ST_ACCEPTED,        24'd0, 16'd0, 8'h00},
      '{CMD_END,  8'h00,        1'b1, ST_UNMATCHED_OPEN,  24'd1, 16'd1, RD_OPEN},
      // closer on an empty stack halts; halted bytes and end keep the frozen spot
      '{CMD_BYTE, SQ_CLOSE,     1'b1, ST_UNMATCHED_CLOSE, 24'd1, 16'd1, SQ_CLOSE},
      '{CMD_BYTE, SQ_OPEN,      1'b1, ST_HALTED,          24'd1, 16'd1, 8'h00},
      '{CMD_BYTE, NEWLINE_BYTE, 1'b1, ST_HALTED,          24'd1, 16'd1, 8'h00},
      '{CMD_END,  8'h00,        1'b1, ST_HALTED,          24'd1, 16'd1, 8'h00},
      // closer against the wrong top
      '{CMD_BYTE, CU_OPEN,      1'b0, ST_ACCEPTED,        24'd0, 16'd0, 8'h00},
      '{CMD_BYTE, RD_CLOSE,     1'b1, ST_UNMATCHED_CLOSE, 24'd1, 16'd2, RD_CLOSE},
      '{CMD_END,  8'h00,        1'b1, ST_HALTED,          24'd1, 16'd2, 8'h00},
      // end of text ignores its byte field
      '{CMD_END,  8'hFF,        1'b1, ST_BALANCED,        24'd1, 16'd0, 8'h00}
    };

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Phase 1: sender mostly busy, receiver stalls a lot; reset list
    send_idle_pct = 10;
    recv_idle_pct = 55;
    for (i = 0; i < DIRECTED_ROWS; i++)
      send_request('{directed_table[i].cmd, directed_table[i].text}, directed_table[i].typed,
                   '{directed_table[i].st, directed_table[i].row, directed_table[i].col,
                     directed_table[i].sym});
    random_documents(250);

    // Phase 2: roles swapped; full-length list, then an odd-length one
    quiesce();
    send_idle_pct = 55;
    recv_idle_pct = 10;
    stage_random_list(SYMBOL_SLOTS);
    apply_list();
    random_documents(200);
    quiesce();
    stage_random_list(2 * $urandom_range(1, 20) + 1);
    apply_list();
    random_documents(150);

    // Extremes: empty list (all plain text), then all 0xFF (one opener, no closer)
    quiesce();
    stage_uniform_list('0);
    apply_list();
    random_documents(60);
    quiesce();
    stage_uniform_list('1);
    apply_list();
    random_documents(60);

    // Phase 3: no idling; back to the reset list
    quiesce();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    stage_uniform_list('0);
    staged_words[0] = SYMBOL_WORD0_RESET;
    apply_list();
    random_documents(180);

    quiesce();
    $display("Checked %0d results for %0d requests over %0d symbol lists",
             results_checked, requests_sent, lists_loaded);
    $display(
      "Statuses: accepted %0d, bad close %0d, open left %0d, overflow %0d, ok %0d, halted %0d",
      status_tally[ST_ACCEPTED], status_tally[ST_UNMATCHED_CLOSE],
      status_tally[ST_UNMATCHED_OPEN], status_tally[ST_OVERFLOW],
      status_tally[ST_BALANCED], status_tally[ST_HALTED]);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatching or unexpected results", mismatch_count);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
